// ----- sv/shadow_memory_access_checker_unit_macros.svh -----
// ----------------------------------------------------------------------------
// shadow memory access checker assertion macros
// shared concurrent assertion forms, sampled on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SHADOW_MEMORY_ACCESS_CHECKER_UNIT_MACROS_SVH
`define SHADOW_MEMORY_ACCESS_CHECKER_UNIT_MACROS_SVH

// consequent must hold in the same cycle
`define SMAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the next cycle
`define SMAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/smac_pkg.sv -----
// ----------------------------------------------------------------------------
// smac_pkg
// shared constants, codes and types of the shadow memory access checker
// ----------------------------------------------------------------------------
package smac_pkg;

    localparam int GRANULE_SHIFT  = 3;
    localparam int SHADOW_ENTRIES = 4096;

    localparam int GRAN_SIZE = 1 << GRANULE_SHIFT;
    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 16;
    localparam int CNT_W     = LEN_W + 1;
    localparam int OFF_W     = GRANULE_SHIFT;
    localparam int GIDX_W    = ADDR_W - GRANULE_SHIFT;
    localparam int IDX_W     = $clog2(SHADOW_ENTRIES);
    localparam int SHADOW_W  = 8;
    localparam int CMD_W     = 2;
    localparam int REG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_CHECK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POISON   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNPOISON = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_WINDOW_BASE = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_END  = 1'd1;

    localparam logic [ADDR_W-1:0] WINDOW_BASE_RST = 32'd0;
    localparam logic [ADDR_W-1:0] WINDOW_END_RST  = 32'd32768;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHK_RD,
        ST_CHK_EVAL,
        ST_UPD
    } state_t;

    typedef enum logic [1:0] {
        KIND_FINISH,
        KIND_CHECK,
        KIND_UPDATE
    } kind_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic chk_read;
        logic chk_eval;
        logic upd_write;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  clr_last;
        logic  chk_stop;
        logic  upd_last;
    } dp_status_t;

endpackage

// ----- sv/shadow_memory_access_checker_unit.sv -----
// ----------------------------------------------------------------------------
// shadow_memory_access_checker_unit
// shadow byte store per granule of a ram window with check, poison and
// unpoison transactions
// ----------------------------------------------------------------------------
// after reset busy stays high for a clearing pass over all 4096 shadow entries,
// one entry a cycle. a transaction is taken when start is high and busy is low;
// its result shows on done for one cycle and must be taken then. zero length,
// unused command or refused range: done in the cycle after start. check: read,
// then evaluate each touched granule up to the first poisoned byte. poison and
// unpoison: one step per touched granule, writing its entry if in the store
// (for unpoison, if the granule starts in the range). done follows the last
// step, and busy is low again while it is high. the user must write window
// registers only while busy and done are low; the block does not enforce it.
module shadow_memory_access_checker_unit import smac_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [CMD_W-1:0]     command,
    input  logic [ADDR_W-1:0]    address,
    input  logic [LEN_W-1:0]     length,
    input  logic [SHADOW_W-1:0]  poison_value,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    output logic                 done,
    output logic                 range_error,
    output logic                 poisoned,
    output logic [LEN_W-1:0]     bad_offset
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    smac_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    smac_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .command      (command),
        .address      (address),
        .length       (length),
        .poison_value (poison_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .range_error  (range_error),
        .poisoned     (poisoned),
        .bad_offset   (bad_offset)
    );

endmodule

// ----- sv/smac_ram.sv -----
// ----------------------------------------------------------------------------
// smac_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module smac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/smac_ctrl.sv -----
// ----------------------------------------------------------------------------
// smac_ctrl
// sequencer: shadow clearing pass, granule walk for check and update
// ----------------------------------------------------------------------------
`include "shadow_memory_access_checker_unit_macros.svh"

module smac_ctrl import smac_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (status.kind)
                        KIND_CHECK:  state_next = ST_CHK_RD;
                        KIND_UPDATE: state_next = ST_UPD;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CHK_RD:
            begin
                state_next = ST_CHK_EVAL;
            end
            ST_CHK_EVAL:
            begin
                state_next = status.chk_stop ? ST_IDLE : ST_CHK_RD;
            end
            ST_UPD:
            begin
                if (status.upd_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy          = 1'b1;
        cmd.load      = 1'b0;
        cmd.clr_step  = 1'b0;
        cmd.chk_read  = 1'b0;
        cmd.chk_eval  = 1'b0;
        cmd.upd_write = 1'b0;
        cmd.finish    = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.load   = accept;
                cmd.finish = accept && (status.kind == KIND_FINISH);
            end
            ST_CHK_RD:
            begin
                cmd.chk_read = 1'b1;
            end
            ST_CHK_EVAL:
            begin
                cmd.chk_eval = 1'b1;
                cmd.finish   = status.chk_stop;
            end
            ST_UPD:
            begin
                cmd.upd_write = 1'b1;
                cmd.finish    = status.upd_last;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    `SMAC_ASSERT_NEXT(a_read_then_eval, state_reg == ST_CHK_RD, state_reg == ST_CHK_EVAL, "granule read not followed by evaluation")
    `SMAC_ASSERT_NOW(a_no_finish_in_clear, state_reg == ST_CLEAR, !cmd.finish && !cmd.load, "transaction activity during clearing pass")
    `SMAC_ASSERT_NEXT(a_finish_to_idle, cmd.finish, state_reg == ST_IDLE, "sequencer not idle after finishing")

endmodule

// ----- sv/smac_dp.sv -----
// ----------------------------------------------------------------------------
// smac_dp
// datapath: window registers, shadow store, granule walk and result registers
// ----------------------------------------------------------------------------
`include "shadow_memory_access_checker_unit_macros.svh"

module smac_dp import smac_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    input  logic [CMD_W-1:0]     command,
    input  logic [ADDR_W-1:0]    address,
    input  logic [LEN_W-1:0]     length,
    input  logic [SHADOW_W-1:0]  poison_value,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    output logic                 done,
    output logic                 range_error,
    output logic                 poisoned,
    output logic [LEN_W-1:0]     bad_offset
);

    logic [ADDR_W-1:0]   window_base_reg, window_base_next;
    logic [ADDR_W-1:0]   window_end_reg, window_end_next;
    logic [IDX_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                done_reg, done_next;

    logic                range_error_reg, range_error_next;
    logic                poisoned_reg, poisoned_next;
    logic [LEN_W-1:0]    bad_offset_reg, bad_offset_next;
    logic [GIDX_W-1:0]   gran_reg, gran_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    consumed_reg, consumed_next;
    logic [ADDR_W-1:0]   begin_reg, begin_next;
    logic [ADDR_W-1:0]   end_reg, end_next;
    logic [GIDX_W-1:0]   glast_reg, glast_next;
    logic [SHADOW_W-1:0] pval_reg, pval_next;
    logic                poison_reg, poison_next;
    logic                in_store_reg, in_store_next;

    // start-time decode
    logic [ADDR_W:0]     in_sum;
    logic [ADDR_W-1:0]   last_addr;
    logic                is_noop;
    logic                out_of_window;
    logic                load_err;
    kind_t               kind;

    // granule indexing
    logic [GIDX_W-1:0]   g0;
    logic [GIDX_W-1:0]   gdiff;
    logic                in_store;
    logic [IDX_W-1:0]    idx;

    // check evaluation
    logic [SHADOW_W-1:0] shadow;
    logic [OFF_W:0]      avail;
    logic                fits;
    logic [OFF_W-1:0]    last_byte;
    logic                partial;
    logic [OFF_W-1:0]    first_bad;
    logic                hit;
    logic [CNT_W-1:0]    hit_offset;

    // update write
    logic [ADDR_W-1:0]   gb;
    logic [ADDR_W:0]     ge;
    logic                covered_lo;
    logic                full;
    logic [SHADOW_W-1:0] upd_data;
    logic                upd_we;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [SHADOW_W-1:0] ram_wdata;

    assign in_sum        = {1'b0, address} + {{(ADDR_W + 1 - LEN_W){1'b0}}, length};
    assign last_addr     = in_sum[ADDR_W-1:0] - ADDR_W'(1);
    assign is_noop       = (length == '0) || (command == CMD_UNUSED);
    assign out_of_window = (address < window_base_reg) || (in_sum > {1'b0, window_end_reg});

    always_comb
    begin
        load_err = 1'b0;
        if (is_noop)
        begin
            kind = KIND_FINISH;
        end
        else if (command == CMD_CHECK)
        begin
            kind = KIND_CHECK;
        end
        else if (out_of_window)
        begin
            kind     = KIND_FINISH;
            load_err = 1'b1;
        end
        else
        begin
            kind = KIND_UPDATE;
        end
    end

    assign g0       = window_base_reg[ADDR_W-1:GRANULE_SHIFT];
    assign gdiff    = gran_reg - g0;
    assign in_store = (gran_reg >= g0) && (gdiff < GIDX_W'(SHADOW_ENTRIES));
    assign idx      = gdiff[IDX_W-1:0];

    // first poisoned byte of the touched part of the current granule
    assign avail     = (OFF_W + 1)'(GRAN_SIZE) - {1'b0, off_reg};
    assign fits      = rem_reg <= {{(CNT_W - OFF_W - 1){1'b0}}, avail};
    assign last_byte = fits ? (off_reg + rem_reg[OFF_W-1:0] - OFF_W'(1))
                            : OFF_W'(GRAN_SIZE - 1);
    assign partial   = shadow < SHADOW_W'(GRAN_SIZE);
    assign first_bad = (partial && (shadow[OFF_W-1:0] > off_reg)) ? shadow[OFF_W-1:0] : off_reg;
    assign hit       = in_store_reg && (shadow != '0) && (first_bad <= last_byte);
    assign hit_offset = consumed_reg + {{(CNT_W - OFF_W){1'b0}}, first_bad - off_reg};

    assign gb         = {gran_reg, {OFF_W{1'b0}}};
    assign ge         = {1'b0, gb} + (ADDR_W + 1)'(GRAN_SIZE);
    assign covered_lo = begin_reg <= gb;
    assign full       = {1'b0, end_reg} >= ge;
    assign upd_data   = poison_reg ? pval_reg : (full ? '0 : SHADOW_W'(end_reg - gb));
    assign upd_we     = in_store && (poison_reg || covered_lo);

    assign ram_we    = cmd.clr_step || (cmd.upd_write && upd_we);
    assign ram_waddr = cmd.clr_step ? clr_cnt_reg : idx;
    assign ram_wdata = cmd.clr_step ? '0 : upd_data;

    smac_ram #(
        .WIDTH (SHADOW_W),
        .DEPTH (SHADOW_ENTRIES)
    ) u_shadow (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx),
        .rdata (shadow)
    );

    assign status.kind     = kind;
    assign status.clr_last = clr_cnt_reg == IDX_W'(SHADOW_ENTRIES - 1);
    assign status.chk_stop = hit || fits;
    assign status.upd_last = gran_reg == glast_reg;

    always_comb
    begin
        window_base_next = window_base_reg;
        window_end_next  = window_end_reg;
        clr_cnt_next     = clr_cnt_reg;
        done_next        = cmd.finish;
        range_error_next = range_error_reg;
        poisoned_next    = poisoned_reg;
        bad_offset_next  = bad_offset_reg;
        gran_next        = gran_reg;
        off_next         = off_reg;
        rem_next         = rem_reg;
        consumed_next    = consumed_reg;
        begin_next       = begin_reg;
        end_next         = end_reg;
        glast_next       = glast_reg;
        pval_next        = pval_reg;
        poison_next      = poison_reg;
        in_store_next    = in_store_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_BASE: window_base_next = cfg_data;
                REG_WINDOW_END:  window_end_next  = cfg_data;
                default:         window_base_next = window_base_reg;
            endcase
        end

        if (cmd.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + IDX_W'(1);
        end

        if (cmd.load)
        begin
            gran_next        = address[ADDR_W-1:GRANULE_SHIFT];
            off_next         = address[OFF_W-1:0];
            rem_next         = {1'b0, length};
            consumed_next    = '0;
            begin_next       = address;
            end_next         = in_sum[ADDR_W-1:0];
            glast_next       = last_addr[ADDR_W-1:GRANULE_SHIFT];
            pval_next        = poison_value;
            poison_next      = command == CMD_POISON;
            range_error_next = load_err;
            poisoned_next    = 1'b0;
            bad_offset_next  = '0;
        end

        if (cmd.chk_read)
        begin
            in_store_next = in_store;
        end

        if (cmd.chk_eval)
        begin
            if (hit)
            begin
                poisoned_next   = 1'b1;
                bad_offset_next = hit_offset[LEN_W-1:0];
            end
            gran_next     = gran_reg + GIDX_W'(1);
            off_next      = '0;
            consumed_next = consumed_reg + CNT_W'(avail);
            rem_next      = fits ? '0 : (rem_reg - CNT_W'(avail));
        end

        if (cmd.upd_write)
        begin
            gran_next = gran_reg + GIDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_base_reg <= WINDOW_BASE_RST;
            window_end_reg  <= WINDOW_END_RST;
            clr_cnt_reg     <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            window_base_reg <= window_base_next;
            window_end_reg  <= window_end_next;
            clr_cnt_reg     <= clr_cnt_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        range_error_reg <= range_error_next;
        poisoned_reg    <= poisoned_next;
        bad_offset_reg  <= bad_offset_next;
        gran_reg        <= gran_next;
        off_reg         <= off_next;
        rem_reg         <= rem_next;
        consumed_reg    <= consumed_next;
        begin_reg       <= begin_next;
        end_reg         <= end_next;
        glast_reg       <= glast_next;
        pval_reg        <= pval_next;
        poison_reg      <= poison_next;
        in_store_reg    <= in_store_next;
    end

    assign done        = done_reg;
    assign range_error = range_error_reg;
    assign poisoned    = poisoned_reg;
    assign bad_offset  = bad_offset_reg;

    `SMAC_ASSERT_NOW(a_error_excludes_poison, done_reg && poisoned_reg, !range_error_reg, "range error reported together with poisoned byte")
    `SMAC_ASSERT_NOW(a_offset_only_on_poison, done_reg && !poisoned_reg, bad_offset_reg == '0, "nonzero offset without poisoned byte")
    `SMAC_ASSERT_NOW(a_eval_after_read, cmd.chk_eval, $past(cmd.chk_read), "shadow evaluated without a read one cycle earlier")

endmodule

// ----- test/smac_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smac_result_checker
// mirrors the window registers and the shadow store of the unit, predicts the
// verdict of every accepted transaction and compares it field by field with
// the result that the unit reports on done
// ----------------------------------------------------------------------------
module smac_result_checker import smac_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [CMD_W-1:0]     command,
    input  logic [ADDR_W-1:0]    address,
    input  logic [LEN_W-1:0]     length,
    input  logic [SHADOW_W-1:0]  poison_value,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 done,
    input  logic                 range_error,
    input  logic                 poisoned,
    input  logic [LEN_W-1:0]     bad_offset,
    output int                   open_count,
    output int                   mismatch_count
);

    typedef struct packed {
        logic             range_error;
        logic             poisoned;
        logic [LEN_W-1:0] bad_offset;
    } verdict_t;

    logic [SHADOW_W-1:0] shadow_copy [SHADOW_ENTRIES];
    logic [ADDR_W-1:0]   win_base;
    logic [ADDR_W-1:0]   win_end;
    verdict_t            pending_verdicts [$];
    verdict_t            want;
    int                  errors;

    function automatic bit byte_is_poisoned(input logic [ADDR_W-1:0] a);
        longint unsigned   g;
        longint unsigned   g0;
        longint unsigned   idx;
        logic [SHADOW_W-1:0] v;
        g  = a >> GRANULE_SHIFT;
        g0 = win_base >> GRANULE_SHIFT;
        if (g < g0)
            return 1'b0;
        idx = g - g0;
        if (idx >= SHADOW_ENTRIES)
            return 1'b0;
        v = shadow_copy[idx[IDX_W-1:0]];
        if (v == 0)
            return 1'b0;
        if (v < GRAN_SIZE)
            return a[GRANULE_SHIFT-1:0] >= v;
        return 1'b1;
    endfunction

    // verdict of one transaction; updates the shadow copy as the unit would
    function automatic verdict_t predict_verdict(
        input logic [CMD_W-1:0]    cmd,
        input logic [ADDR_W-1:0]   addr,
        input logic [LEN_W-1:0]    len,
        input logic [SHADOW_W-1:0] pval
    );
        verdict_t            v;
        logic [ADDR_W-1:0]   a;
        logic [ADDR_W:0]     stop;
        logic [SHADOW_W-1:0] fill;
        longint unsigned     g;
        longint unsigned     g0;
        longint unsigned     glast;
        longint unsigned     gb;
        longint unsigned     idx;
        v = '0;
        if (len == 0 || cmd == CMD_UNUSED)
            return v;
        if (cmd == CMD_CHECK)
        begin
            for (int i = 0; i < len; i++)
            begin
                a = addr + i;
                if (byte_is_poisoned(a))
                begin
                    v.poisoned   = 1'b1;
                    v.bad_offset = i[LEN_W-1:0];
                    break;
                end
            end
            return v;
        end
        stop = {1'b0, addr} + len;
        if (addr < win_base || stop > {1'b0, win_end})
        begin
            v.range_error = 1'b1;
            return v;
        end
        g0    = win_base >> GRANULE_SHIFT;
        glast = (stop - 1) >> GRANULE_SHIFT;
        for (g = addr >> GRANULE_SHIFT; g <= glast; g++)
        begin
            idx = g - g0;
            gb  = g << GRANULE_SHIFT;
            if (idx < SHADOW_ENTRIES)
            begin
                if (cmd == CMD_POISON)
                    shadow_copy[idx[IDX_W-1:0]] = pval;
                else if (addr <= gb)
                begin
                    fill = SHADOW_W'(stop - gb);
                    shadow_copy[idx[IDX_W-1:0]] = (stop >= gb + GRAN_SIZE) ? '0 : fill;
                end
            end
        end
        return v;
    endfunction

    task automatic note_mismatch(input string field, input int exp_val, input int act_val);
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_val,
                 act_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (shadow_copy[k])
                shadow_copy[k] = '0;
            win_base = WINDOW_BASE_RST;
            win_end  = WINDOW_END_RST;
            pending_verdicts.delete();
            errors = 0;
            open_count     <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_WINDOW_BASE)
                    win_base = cfg_data;
                else
                    win_end = cfg_data;
            end
            if (done)
            begin
                if (pending_verdicts.size() == 0)
                    note_mismatch("unexpected transaction, bad_offset", -1, bad_offset);
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (want.range_error !== range_error)
                        note_mismatch("range_error", want.range_error, range_error);
                    if (want.poisoned !== poisoned)
                        note_mismatch("poisoned", want.poisoned, poisoned);
                    if (want.bad_offset !== bad_offset)
                        note_mismatch("bad_offset", want.bad_offset, bad_offset);
                end
            end
            if (start && !busy)
                pending_verdicts.push_back(predict_verdict(command, address, length,
                                                           poison_value));
            open_count     <= pending_verdicts.size();
            mismatch_count <= errors;
        end
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives check, poison and unpoison transactions into the shadow memory
// access checker under several window settings, in random bursts, and gives
// the verdict from the checker's mismatch and open counts
// ----------------------------------------------------------------------------
module tb;
    import smac_pkg::*;

    localparam int PHASES     = 7;
    localparam int PHASE_ITEMS = 172;

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 start        = 1'b0;
    logic [CMD_W-1:0]     command      = CMD_CHECK;
    logic [ADDR_W-1:0]    address      = '0;
    logic [LEN_W-1:0]     length       = '0;
    logic [SHADOW_W-1:0]  poison_value = '0;
    logic                 cfg_we       = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index    = REG_WINDOW_BASE;
    logic [ADDR_W-1:0]    cfg_data     = '0;
    logic                 busy;
    logic                 done;
    logic                 range_error;
    logic                 poisoned;
    logic [LEN_W-1:0]     bad_offset;
    int                   open_count;
    int                   mismatch_count;

    logic [ADDR_W-1:0] cur_base = WINDOW_BASE_RST;
    logic [ADDR_W-1:0] cur_end  = WINDOW_END_RST;
    logic [ADDR_W-1:0] phase_base [PHASES];
    logic [ADDR_W-1:0] phase_end  [PHASES];
    int                burst_left = 0;
    bit                start_hi   = 1'b0;
    int                accepted   = 0;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    shadow_memory_access_checker_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .address      (address),
        .length       (length),
        .poison_value (poison_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .range_error  (range_error),
        .poisoned     (poisoned),
        .bad_offset   (bad_offset)
    );

    smac_result_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .address        (address),
        .length         (length),
        .poison_value   (poison_value),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .range_error    (range_error),
        .poisoned       (poisoned),
        .bad_offset     (bad_offset),
        .open_count     (open_count),
        .mismatch_count (mismatch_count)
    );

    task automatic issue(
        input logic [CMD_W-1:0]    cmd,
        input logic [ADDR_W-1:0]   addr,
        input logic [LEN_W-1:0]    len,
        input logic [SHADOW_W-1:0] pval
    );
        start        <= 1'b1;
        start_hi     = 1'b1;
        command      <= cmd;
        address      <= addr;
        length       <= len;
        poison_value <= pval;
        do
            @(posedge clk);
        while (busy);
        accepted++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            start    <= 1'b0;
            start_hi = 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
    endtask

    task automatic drain();
        if (start_hi)
        begin
            start    <= 1'b0;
            start_hi = 1'b0;
        end
        burst_left = 0;
        do
            @(posedge clk);
        while (open_count != 0 || busy);
    endtask

    task automatic set_window(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WINDOW_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_index <= REG_WINDOW_END;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_base = base;
        cur_end  = limit;
    endtask

    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] span;
        span = (cur_end > cur_base) ? cur_end - cur_base : 32'd64;
        if (span > 32'd33000)
            span = 32'd33000;
        case ($urandom_range(0, 15))
            0:       return $urandom();
            1:       return cur_end - $urandom_range(0, 64);
            2:       return cur_base - $urandom_range(1, 64);
            3:       return 32'hFFFF_FFFF - $urandom_range(0, 64);
            4, 5, 6: return cur_base + $urandom_range(0, 511);
            default: return cur_base + $urandom_range(0, span - 1);
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 199);
        if (r == 0)
            return LEN_W'($urandom_range(4096, 65535));
        if (r < 8)
            return '0;
        if (r < 40)
            return LEN_W'($urandom_range(17, 300));
        return LEN_W'($urandom_range(1, 16));
    endfunction

    function automatic logic [SHADOW_W-1:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return SHADOW_W'($urandom_range(1, GRAN_SIZE - 1));
        return SHADOW_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CMD_W-1:0] pick_command();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return CMD_UNUSED;
        if (r < 7)
            return CMD_CHECK;
        if (r < 12)
            return CMD_POISON;
        return CMD_UNPOISON;
    endfunction

    task automatic random_step();
        logic [ADDR_W-1:0] a;
        logic [LEN_W-1:0]  l;
        a = pick_address();
        l = pick_length();
        if ($urandom_range(0, 9) < 4)
            issue(pick_command(), a, l, pick_value());
        else
        begin
            // poison, look across it, unpoison part of it, look again
            issue(CMD_POISON, a, l, pick_value());
            issue(CMD_CHECK, a - $urandom_range(0, 9), LEN_W'(l + $urandom_range(0, 18)),
                  pick_value());
            issue(CMD_UNPOISON, a + $urandom_range(0, 9), LEN_W'($urandom_range(0, l)),
                  pick_value());
            issue(CMD_CHECK, a, l, pick_value());
        end
    endtask

    task automatic window_edges();
        issue(CMD_POISON, cur_base, 1, 8'hFF);
        issue(CMD_CHECK, cur_base - 4, 8, 8'h00);
        issue(CMD_POISON, cur_end - 8, 8, 8'h05);
        issue(CMD_POISON, cur_end - 7, 8, 8'hAA);
        issue(CMD_CHECK, cur_end - 16, 32, 8'h00);
        issue(CMD_UNPOISON, cur_base, 16'hFFFF, 8'h00);
    endtask

    task automatic directed_cases();
        issue(CMD_CHECK, 32'h0, 1, 8'h00);
        issue(CMD_POISON, 32'h10, 8, 8'hFF);
        issue(CMD_CHECK, 32'h0C, 8, 8'h00);
        issue(CMD_UNPOISON, 32'h10, 5, 8'h00);
        issue(CMD_CHECK, 32'h10, 8, 8'h00);
        issue(CMD_POISON, 32'h21, 20, 8'h03);
        issue(CMD_UNPOISON, 32'h22, 14, 8'h00);
        issue(CMD_CHECK, 32'h20, 24, 8'h00);
        issue(CMD_UNUSED, 32'h10, 5, 8'hFF);
        issue(CMD_POISON, 32'h40, 0, 8'hFF);
        issue(CMD_POISON, 32'd32760, 16, 8'hFF);
        issue(CMD_POISON, 32'd32760, 8, 8'h80);
        issue(CMD_CHECK, 32'd32752, 16'hFFFF, 8'h00);
        issue(CMD_POISON, 32'h100, 1, 8'h08);
        issue(CMD_CHECK, 32'hFFFF_FFFF, 16'hFFFF, 8'h00);
        issue(CMD_UNPOISON, 32'h0, 16'h8000, 8'h00);
        issue(CMD_CHECK, 32'h0, 16'hFFFF, 8'h00);
        issue(CMD_POISON, 32'hFFFF_FFFF, 2, 8'h55);
        issue(CMD_UNPOISON, 32'hFFFF_FFFF, 16'hFFFF, 8'h00);
    endtask

    initial
    begin
        phase_base[0] = WINDOW_BASE_RST;  phase_end[0] = WINDOW_END_RST;
        phase_base[1] = 32'h0001_0000;    phase_end[1] = 32'h0001_8000;
        phase_base[2] = 32'h8000_0000;    phase_end[2] = 32'hFFFF_FFFF;
        phase_base[3] = 32'hFFFF_0000;    phase_end[3] = 32'hFFFF_FFFF;
        phase_base[4] = 32'h0000_4000;    phase_end[4] = 32'h0000_0000;
        phase_base[5] = 32'h0000_0103;    phase_end[5] = 32'h0000_2000;
        phase_base[6] = 32'h0000_0000;    phase_end[6] = 32'h0000_1800;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                drain();
                set_window(phase_base[p], phase_end[p]);
            end
            else
                directed_cases();
            window_edges();
            while (accepted < (p + 1) * PHASE_ITEMS)
                random_step();
        end
        drain();
        repeat (16)
            @(posedge clk);
        if (mismatch_count == 0 && open_count == 0)
            $display("shadow_memory_access_checker_unit test passed");
        else
            $display("shadow_memory_access_checker_unit test failed");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("shadow_memory_access_checker_unit test failed");
        $finish;
    end

endmodule
